// File: sv/lms_daltonize_pixel_core_assert.svh
// Assertion macros shared by the pixel core RTL.
`ifndef LMS_DALTONIZE_PIXEL_CORE_ASSERT_SVH
`define LMS_DALTONIZE_PIXEL_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LDS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lds assertion failed");
`define LDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lds assertion failed");
`else
`define LDS_ASSERT_NOW(label, clk, rst, ante, cons)
`define LDS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: sv/lds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lds_pkg;

   localparam int FRAC_BITS = 16;
   localparam int CH_W      = 8;
   localparam int DAT_W     = FRAC_BITS + 17;
   localparam int COEF_W    = FRAC_BITS + 3;
   localparam int LCOEF_W   = FRAC_BITS + 7;
   localparam int PROD_W    = DAT_W + COEF_W;
   localparam int NSTAGE    = 7;

   localparam longint unsigned DEC_SCALE = 64'd1000000000000;

   localparam logic [1:0] MODE_PROTAN = 2'd0;
   localparam logic [1:0] MODE_DEUTAN = 2'd1;
   localparam logic [1:0] MODE_TRITAN = 2'd2;

   localparam longint RGB2LMS_E12 [3][3] = '{
      '{64'sd17882400000000, 64'sd43516100000000, 64'sd4119350000000},
      '{64'sd3455650000000,  64'sd27155400000000, 64'sd3867140000000},
      '{64'sd29956600000,    64'sd184309000000,   64'sd1467090000000}
   };

   localparam longint SIM_E12 [3][3][3] = '{
      '{'{64'sd0, 64'sd2023440000000, -64'sd2525810000000},
        '{64'sd0, 64'sd1000000000000, 64'sd0},
        '{64'sd0, 64'sd0, 64'sd1000000000000}},
      '{'{64'sd1000000000000, 64'sd0, 64'sd0},
        '{64'sd494207000000, 64'sd0, 64'sd1248270000000},
        '{64'sd0, 64'sd0, 64'sd1000000000000}},
      '{'{64'sd1000000000000, 64'sd0, 64'sd0},
        '{64'sd0, 64'sd1000000000000, 64'sd0},
        '{-64'sd395913000000, 64'sd801109000000, 64'sd0}}
   };

   localparam longint LMS2RGB_E12 [3][3] = '{
      '{64'sd80944447900,  -64'sd130504409000, 64'sd116721066000},
      '{-64'sd10248533500, 64'sd54019326600,   -64'sd113614708000},
      '{-64'sd365296938,   -64'sd4121614690,   64'sd693511405000}
   };

   localparam longint SPREAD_E12 = 64'sd700000000000;

   typedef logic signed [DAT_W-1:0]   lds_dat_type;
   typedef logic signed [COEF_W-1:0]  lds_coef_type;
   typedef logic signed [LCOEF_W-1:0] lds_lcoef_type;
   typedef logic signed [PROD_W-1:0]  lds_prod_type;

   typedef struct packed {
      logic [CH_W-1:0] red_in;
      logic [CH_W-1:0] green_in;
      logic [CH_W-1:0] blue_in;
   } lds_req_type;

   typedef struct packed {
      logic [CH_W-1:0] red_out;
      logic [CH_W-1:0] green_out;
      logic [CH_W-1:0] blue_out;
   } lds_rsp_type;

   typedef struct packed {
      logic ld_first;
      logic ld_second;
   } lds_ld2_type;

   // Decimal constant scaled by 1e12 to fixed point, ties away from zero.
   function automatic longint lds_quant(longint num);
      longint unsigned mag;
      longint unsigned ip;
      longint unsigned rem;
      longint unsigned q;
      mag = (num < 0) ? longint'(-num) : longint'(num);
      ip  = mag / DEC_SCALE;
      rem = mag % DEC_SCALE;
      q   = (ip << FRAC_BITS) + (((rem << FRAC_BITS) + DEC_SCALE / 2) / DEC_SCALE);
      return (num < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic lds_lcoef_type lds_lms_coef(int i, int j);
      return LCOEF_W'(lds_quant(RGB2LMS_E12[i][j]));
   endfunction

   function automatic lds_coef_type lds_sim_coef(logic [1:0] mode, int i, int j);
      lds_coef_type cp;
      lds_coef_type cd;
      lds_coef_type ct;
      cp = COEF_W'(lds_quant(SIM_E12[0][i][j]));
      cd = COEF_W'(lds_quant(SIM_E12[1][i][j]));
      ct = COEF_W'(lds_quant(SIM_E12[2][i][j]));
      unique case (mode)
         MODE_PROTAN: return cp;
         MODE_DEUTAN: return cd;
         MODE_TRITAN: return ct;
         default:     return ct;
      endcase
   endfunction

   function automatic lds_coef_type lds_back_coef(int i, int j);
      return COEF_W'(lds_quant(LMS2RGB_E12[i][j]));
   endfunction

   function automatic lds_coef_type lds_spread_coef();
      return COEF_W'(lds_quant(SPREAD_E12));
   endfunction

   // Drop the fraction of a product, to nearest with ties away from zero.
   function automatic lds_prod_type lds_round(lds_prod_type p);
      lds_prod_type half;
      lds_prod_type bias;
      half = '0;
      half[FRAC_BITS-1] = 1'b1;
      bias = p[PROD_W-1] ? half - lds_prod_type'(1) : half;
      return (p + bias) >>> FRAC_BITS;
   endfunction

   function automatic logic [CH_W-1:0] lds_clamp(logic signed [DAT_W+1:0] v);
      logic signed [DAT_W+1:0] top;
      top = '0;
      top[FRAC_BITS +: CH_W] = '1;
      if (v < 0) begin
         return '0;
      end
      if (v > top) begin
         return '1;
      end
      return v[FRAC_BITS +: CH_W];
   endfunction

endpackage
`default_nettype wire

// File: sv/lds_lms_stage.sv
`timescale 1ns / 1ps
`default_nettype none
module lds_lms_stage (
   input  wire logic                clock,
   input  wire logic                ld,
   input  wire lds_pkg::lds_req_type px,
   output lds_pkg::lds_dat_type     lms_o [3]
);

   lds_pkg::lds_dat_type lms_ff [3];
   lds_pkg::lds_dat_type lms_in [3];
   logic [lds_pkg::CH_W-1:0] ch [3];

   always_comb begin
      lds_pkg::lds_dat_type acc;
      lds_pkg::lds_dat_type p;
      ch[0] = px.red_in;
      ch[1] = px.green_in;
      ch[2] = px.blue_in;
      for (int i = 0; i < 3; i++) begin
         acc = '0;
         for (int j = 0; j < 3; j++) begin
            p   = lds_pkg::lds_lms_coef(i, j) * $signed({1'b0, ch[j]});
            acc = acc + p;
         end
         lms_in[i] = acc;
      end
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         for (int i = 0; i < 3; i++) begin
            lms_ff[i] <= lms_in[i];
         end
      end
   end

   assign lms_o = lms_ff;

endmodule
`default_nettype wire

// File: sv/lds_mat_stage.sv
`timescale 1ns / 1ps
`default_nettype none
module lds_mat_stage (
   input  wire logic                 clock,
   input  wire lds_pkg::lds_ld2_type ctl,
   input  wire lds_pkg::lds_dat_type  vec_i [3],
   input  wire lds_pkg::lds_coef_type coef_i [3][3],
   output lds_pkg::lds_dat_type       vec_o [3]
);

   lds_pkg::lds_prod_type prod_ff [3][3];
   lds_pkg::lds_prod_type prod_in [3][3];
   lds_pkg::lds_dat_type  sum_ff [3];
   lds_pkg::lds_dat_type  sum_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = vec_i[j] * coef_i[i][j];
         end
      end
   end

   always_comb begin
      logic signed [lds_pkg::DAT_W+1:0] acc;
      for (int i = 0; i < 3; i++) begin
         acc = '0;
         for (int j = 0; j < 3; j++) begin
            acc = acc + (lds_pkg::DAT_W+2)'(lds_pkg::lds_round(prod_ff[i][j]));
         end
         sum_in[i] = acc[lds_pkg::DAT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_first) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               prod_ff[i][j] <= prod_in[i][j];
            end
         end
      end
      if (ctl.ld_second) begin
         for (int i = 0; i < 3; i++) begin
            sum_ff[i] <= sum_in[i];
         end
      end
   end

   assign vec_o = sum_ff;

endmodule
`default_nettype wire

// File: sv/lds_fix_stage.sv
`timescale 1ns / 1ps
`default_nettype none
module lds_fix_stage (
   input  wire logic                 clock,
   input  wire lds_pkg::lds_ld2_type ctl,
   input  wire lds_pkg::lds_req_type px,
   input  wire lds_pkg::lds_dat_type back_i [3],
   output lds_pkg::lds_rsp_type      rsp_o
);

   lds_pkg::lds_prod_type spread_ff;
   lds_pkg::lds_prod_type spread_in;
   lds_pkg::lds_dat_type  err_g_ff;
   lds_pkg::lds_dat_type  err_g_in;
   lds_pkg::lds_dat_type  err_b_ff;
   lds_pkg::lds_dat_type  err_b_in;
   lds_pkg::lds_req_type  px_ff;
   lds_pkg::lds_rsp_type  rsp_ff;
   lds_pkg::lds_rsp_type  rsp_in;

   function automatic lds_pkg::lds_dat_type scale_ch(logic [lds_pkg::CH_W-1:0] c);
      return lds_pkg::DAT_W'(c) << lds_pkg::FRAC_BITS;
   endfunction

   always_comb begin
      lds_pkg::lds_dat_type err_r;
      err_r     = scale_ch(px.red_in) - back_i[0];
      err_g_in  = scale_ch(px.green_in) - back_i[1];
      err_b_in  = scale_ch(px.blue_in) - back_i[2];
      spread_in = err_r * lds_pkg::lds_spread_coef();
   end

   always_comb begin
      logic signed [lds_pkg::DAT_W+1:0] spread;
      logic signed [lds_pkg::DAT_W+1:0] g;
      logic signed [lds_pkg::DAT_W+1:0] b;
      spread = (lds_pkg::DAT_W+2)'(lds_pkg::lds_round(spread_ff));
      g = (lds_pkg::DAT_W+2)'(scale_ch(px_ff.green_in)) + spread
          + (lds_pkg::DAT_W+2)'(err_g_ff);
      b = (lds_pkg::DAT_W+2)'(scale_ch(px_ff.blue_in)) + spread
          + (lds_pkg::DAT_W+2)'(err_b_ff);
      rsp_in.red_out   = px_ff.red_in;
      rsp_in.green_out = lds_pkg::lds_clamp(g);
      rsp_in.blue_out  = lds_pkg::lds_clamp(b);
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_first) begin
         spread_ff <= spread_in;
         err_g_ff  <= err_g_in;
         err_b_ff  <= err_b_in;
         px_ff     <= px;
      end
      if (ctl.ld_second) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_o = rsp_ff;

endmodule
`default_nettype wire

// File: sv/lms_daltonize_pixel_core.sv
`timescale 1ns / 1ps
`default_nettype none
`include "lms_daltonize_pixel_core_assert.svh"
// Daltonizes one 8-bit RGB pixel per clock when the result side does not stall: RGB to
// LMS, the simulation matrix chosen by the deficiency mode register (0 protanope, 1
// deuteranope, 2 or 3 tritanope), back to RGB, and the error spread onto green and blue
// before clamping; red passes unchanged. The pipeline has seven register stages, and a
// new item may be accepted every cycle unless a result stall has filled it. Each stage
// holds a valid bit and moves up whenever the stage after it is empty or moving, so
// empty slots are squeezed out under a result stall. Write the mode register only while
// no item is in flight.
module lms_daltonize_pixel_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire lds_pkg::lds_req_type req_item,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      lds_pkg::lds_rsp_type rsp_item,
   input  wire logic                 csr_wr_en,
   input  wire logic [1:0]           csr_wr_data
);

   localparam int NS = lds_pkg::NSTAGE;

   logic [1:0]    mode_ff;
   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_in;
   logic [NS-1:0] adv;
   logic [NS-1:0] hold;

   lds_pkg::lds_req_type  px_ff [5];
   lds_pkg::lds_dat_type  lms [3];
   lds_pkg::lds_dat_type  sim [3];
   lds_pkg::lds_dat_type  back [3];
   lds_pkg::lds_coef_type sim_coef [3][3];
   lds_pkg::lds_coef_type back_coef [3][3];
   lds_pkg::lds_ld2_type  sim_ctl;
   lds_pkg::lds_ld2_type  back_ctl;
   lds_pkg::lds_ld2_type  fix_ctl;

   always_comb begin
      adv[NS-1] = !v_ff[NS-1] || !rsp_stall;
      for (int k = NS - 2; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
      v_in[0] = adv[0] ? req_valid : v_ff[0];
      for (int k = 1; k < NS; k++) begin
         v_in[k] = adv[k] ? v_ff[k-1] : v_ff[k];
      end
      hold = v_ff & ~adv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff    <= '0;
         mode_ff <= lds_pkg::MODE_PROTAN;
      end else begin
         v_ff <= v_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         px_ff[0] <= req_item;
      end
      for (int k = 1; k < 5; k++) begin
         if (adv[k]) begin
            px_ff[k] <= px_ff[k-1];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            sim_coef[i][j]  = lds_pkg::lds_sim_coef(mode_ff, i, j);
            back_coef[i][j] = lds_pkg::lds_back_coef(i, j);
         end
      end
   end

   assign sim_ctl  = '{ld_first: adv[1], ld_second: adv[2]};
   assign back_ctl = '{ld_first: adv[3], ld_second: adv[4]};
   assign fix_ctl  = '{ld_first: adv[5], ld_second: adv[6]};

   lds_lms_stage u_lms (
      .clock (clock),
      .ld    (adv[0]),
      .px    (req_item),
      .lms_o (lms)
   );

   lds_mat_stage u_sim (
      .clock  (clock),
      .ctl    (sim_ctl),
      .vec_i  (lms),
      .coef_i (sim_coef),
      .vec_o  (sim)
   );

   lds_mat_stage u_back (
      .clock  (clock),
      .ctl    (back_ctl),
      .vec_i  (sim),
      .coef_i (back_coef),
      .vec_o  (back)
   );

   lds_fix_stage u_fix (
      .clock  (clock),
      .ctl    (fix_ctl),
      .px     (px_ff[4]),
      .back_i (back),
      .rsp_o  (rsp_item)
   );

   assign req_stall = !adv[0];
   assign rsp_valid = v_ff[NS-1];

   `LDS_ASSERT_NEXT(a_no_drop, clock, reset, (hold != '0), (($past(hold) & ~v_ff) == '0))
   `LDS_ASSERT_NOW(a_stall_full, clock, reset, req_stall, ((&v_ff) && rsp_stall))
   `LDS_ASSERT_NOW(a_out_src, clock, reset, $rose(v_ff[NS-1]), $past(v_ff[NS-2]))

endmodule
`default_nettype wire
